[src/ptw_pkg.sv]
// shared constants, types and address helpers of the page table walker
`default_nettype none
package ptw_pkg;

    localparam int XLEN        = 64;
    localparam bit IS_SV39     = (XLEN >= 64);
    localparam int IDX_BITS    = IS_SV39 ? 9 : 10;
    localparam int PAGE_SHIFT  = 12;
    localparam int TOP_SHIFT   = IS_SV39 ? (9 + 9 + 12) : (10 + 12);
    localparam int ENTRY_SHIFT = IS_SV39 ? 3 : 2;
    localparam int SHIFT_W     = 5;

    localparam logic [63:0] ADDR_MASK = IS_SV39 ? 64'hFFFF_FFFF_FFFF_FFFF
                                                : 64'h0000_0000_FFFF_FFFF;
    localparam logic [63:0] IDX_MASK  = (64'd1 << IDX_BITS) - 64'd1;
    localparam logic [63:0] PAGE_MASK = 64'hFFF;

    localparam logic [3:0] PTE_FLAG_MASK = 4'hF;
    localparam logic [3:0] PTE_POINTER   = 4'h1;
    localparam logic [3:0] SATP_MODE_SV39 = 4'h8;

    localparam logic OP_TRANSLATE = 1'b0;
    localparam logic OP_RESPONSE  = 1'b1;

    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    typedef enum logic [1:0] {
        KIND_READ_REQ = 2'd0,
        KIND_DONE     = 2'd1,
        KIND_REJECT   = 2'd2
    } t_kind;

    // classified beat handed from front to back
    typedef struct packed {
        logic        is_resp;
        logic        paged;
        logic        pointer;
        logic [63:0] addr;
        logic [63:0] va;
    } t_item;

    function automatic logic satp_paged(input logic [63:0] satp);
        logic paged;
        if (IS_SV39) begin
            paged = (satp[63:60] == SATP_MODE_SV39);
        end else begin
            paged = satp[31];
        end
        return paged;
    endfunction

    function automatic logic [63:0] root_base(input logic [63:0] satp);
        logic [63:0] base;
        if (IS_SV39) begin
            base = {{8{satp[43]}}, satp[43:0], 12'h000};
        end else begin
            base = {32'h0, satp[19:0], 12'h000};
        end
        return base;
    endfunction

    function automatic logic [63:0] pte_page(input logic [63:0] pte);
        logic [63:0] page;
        if (IS_SV39) begin
            page = {{8{pte[53]}}, pte[53:10], 12'h000};
        end else begin
            page = {32'h0, pte[29:10], 12'h000};
        end
        return page;
    endfunction

    function automatic logic [63:0] entry_addr(input logic [63:0] base,
                                               input logic [63:0] va,
                                               input logic [SHIFT_W-1:0] shift);
        logic [63:0] idx;
        idx = (va >> shift) & IDX_MASK;
        return (base + (idx << ENTRY_SHIFT)) & ADDR_MASK;
    endfunction

endpackage
`default_nettype wire

[src/page_table_walker_unit.sv]
// Page table walker (Sv39 at XLEN 64, Sv32 at XLEN 32), no permission or fault checks.
// One beat is accepted per clock while the queue has room: the front end decodes it and
// precomputes its address into a two-entry queue, and the back end retires one queued
// beat per clock into the output register while the output is not stalled, so each
// beat gives one result beat. Throughput is set by the back end's single step per beat.
// The user must write translation_control through i_cfg_we/i_cfg_wdata only while no
// beat is in flight; the block does not enforce this.
`default_nettype none
module page_table_walker_unit (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_cfg_we,
    input  wire logic [63:0]   i_cfg_wdata,
    input  wire logic          i_s_tvalid,
    output logic               o_s_tready,
    input  wire logic [127:0]  i_s_tdata,   // virtual_address, entry_word
    input  wire logic          i_s_tuser,   // operation
    output logic               o_m_tvalid,
    input  wire logic          i_m_tready,
    output logic [63:0]        o_m_tdata,   // out_address
    output logic [1:0]         o_m_tuser    // result_kind
);

    logic [63:0]    r_satp;
    ptw_pkg::t_item front_item;
    ptw_pkg::t_item queue_item;
    logic           queue_valid;
    logic           back_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_satp <= '0;
        end else if (i_cfg_we) begin
            r_satp <= i_cfg_wdata;
        end
    end

    ptw_front u_front (
        .i_satp (r_satp),
        .i_op   (i_s_tuser),
        .i_va   (i_s_tdata[63:0]),
        .i_pte  (i_s_tdata[127:64]),
        .o_item (front_item)
    );

    ptw_queue u_queue (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_wr_valid (i_s_tvalid),
        .o_wr_ready (o_s_tready),
        .i_wr_item  (front_item),
        .o_rd_valid (queue_valid),
        .i_rd_ready (back_ready),
        .o_rd_item  (queue_item)
    );

    ptw_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (queue_valid),
        .o_ready    (back_ready),
        .i_item     (queue_item),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser)
    );

endmodule
`default_nettype wire

[src/ptw_front.sv]
// front end: decodes an input beat and precomputes its addresses
`default_nettype none
module ptw_front (
    input  wire logic [63:0]   i_satp,
    input  wire logic          i_op,
    input  wire logic [63:0]   i_va,
    input  wire logic [63:0]   i_pte,
    output ptw_pkg::t_item     o_item
);

    logic        paged;
    logic [63:0] va;
    logic [63:0] root_entry;

    always_comb begin
        paged      = ptw_pkg::satp_paged(i_satp);
        va         = i_va & ptw_pkg::ADDR_MASK;
        root_entry = ptw_pkg::entry_addr(ptw_pkg::root_base(i_satp), va,
                                         ptw_pkg::SHIFT_W'(ptw_pkg::TOP_SHIFT));

        o_item.is_resp = (i_op == ptw_pkg::OP_RESPONSE);
        o_item.paged   = paged;
        o_item.pointer = ((i_pte[3:0] & ptw_pkg::PTE_FLAG_MASK) == ptw_pkg::PTE_POINTER);
        o_item.va      = va;
        if (i_op == ptw_pkg::OP_RESPONSE) begin
            o_item.addr = ptw_pkg::pte_page(i_pte);
        end else if (paged) begin
            o_item.addr = root_entry;
        end else begin
            o_item.addr = va;
        end
    end

endmodule
`default_nettype wire

[src/ptw_queue.sv]
// small fifo between front and back
`default_nettype none
module ptw_queue (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_wr_valid,
    output logic               o_wr_ready,
    input  wire ptw_pkg::t_item i_wr_item,
    output logic               o_rd_valid,
    input  wire logic          i_rd_ready,
    output ptw_pkg::t_item     o_rd_item
);

    ptw_pkg::t_item                  r_mem [ptw_pkg::QUEUE_DEPTH];
    logic [ptw_pkg::QPTR_W-1:0]      r_wr_ptr, n_wr_ptr;
    logic [ptw_pkg::QPTR_W-1:0]      r_rd_ptr, n_rd_ptr;
    logic [ptw_pkg::QCNT_W-1:0]      r_count, n_count;
    logic                            push, pop;

    always_comb begin
        o_wr_ready = (r_count != ptw_pkg::QCNT_W'(ptw_pkg::QUEUE_DEPTH));
        o_rd_valid = (r_count != '0);
        o_rd_item  = r_mem[r_rd_ptr];
        push       = i_wr_valid && o_wr_ready;
        pop        = o_rd_valid && i_rd_ready;

        n_wr_ptr = r_wr_ptr;
        if (push) begin
            n_wr_ptr = (r_wr_ptr == ptw_pkg::QPTR_W'(ptw_pkg::QUEUE_DEPTH - 1))
                       ? '0 : r_wr_ptr + 1'b1;
        end
        n_rd_ptr = r_rd_ptr;
        if (pop) begin
            n_rd_ptr = (r_rd_ptr == ptw_pkg::QPTR_W'(ptw_pkg::QUEUE_DEPTH - 1))
                       ? '0 : r_rd_ptr + 1'b1;
        end
        n_count = r_count;
        if (push && !pop) begin
            n_count = r_count + 1'b1;
        end else if (pop && !push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr_ptr] <= i_wr_item;
        end
    end

endmodule
`default_nettype wire

[src/ptw_back.sv]
// back end: walk state and the registered result beat
`default_nettype none
module ptw_back (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_valid,
    output logic               o_ready,
    input  wire ptw_pkg::t_item i_item,
    output logic               o_m_tvalid,
    input  wire logic          i_m_tready,
    output logic [63:0]        o_m_tdata,
    output logic [1:0]         o_m_tuser
);

    logic                          r_busy, n_busy;
    logic [63:0]                   r_saved_va, n_saved_va;
    logic [ptw_pkg::SHIFT_W-1:0]   r_shift, n_shift;
    logic                          r_out_valid, n_out_valid;
    ptw_pkg::t_kind                r_out_kind, n_out_kind;
    logic [63:0]                   r_out_addr, n_out_addr;

    logic                          pop;
    logic [ptw_pkg::SHIFT_W-1:0]   next_shift;
    logic                          go_deeper;
    logic [63:0]                   low_mask;

    always_comb begin
        pop        = i_valid && (!r_out_valid || i_m_tready);
        o_ready    = !r_out_valid || i_m_tready;
        next_shift = r_shift - ptw_pkg::SHIFT_W'(ptw_pkg::IDX_BITS);
        go_deeper  = i_item.pointer &&
                     (r_shift >= ptw_pkg::SHIFT_W'(ptw_pkg::PAGE_SHIFT + ptw_pkg::IDX_BITS));
        low_mask   = (64'd1 << r_shift) - 64'd1;

        n_busy      = r_busy;
        n_saved_va  = r_saved_va;
        n_shift     = r_shift;
        n_out_valid = r_out_valid && !i_m_tready;
        n_out_kind  = r_out_kind;
        n_out_addr  = r_out_addr;

        if (pop) begin
            n_out_valid = 1'b1;
            n_out_kind  = ptw_pkg::KIND_REJECT;
            n_out_addr  = '0;
            if (!i_item.is_resp && !r_busy) begin
                if (!i_item.paged) begin
                    n_out_kind = ptw_pkg::KIND_DONE;
                    n_out_addr = i_item.addr;
                end else begin
                    n_out_kind = ptw_pkg::KIND_READ_REQ;
                    n_out_addr = i_item.addr;
                    n_busy     = 1'b1;
                    n_saved_va = i_item.va;
                    n_shift    = ptw_pkg::SHIFT_W'(ptw_pkg::TOP_SHIFT);
                end
            end else if (i_item.is_resp && r_busy) begin
                if (go_deeper) begin
                    n_out_kind = ptw_pkg::KIND_READ_REQ;
                    n_out_addr = ptw_pkg::entry_addr(i_item.addr, r_saved_va, next_shift);
                    n_shift    = next_shift;
                end else begin
                    n_out_kind = ptw_pkg::KIND_DONE;
                    n_out_addr = (i_item.addr | (r_saved_va & low_mask)) &
                                 ptw_pkg::ADDR_MASK;
                    n_busy     = 1'b0;
                    n_shift    = '0;
                end
            end
        end

        o_m_tvalid = r_out_valid;
        o_m_tdata  = r_out_addr;
        o_m_tuser  = r_out_kind;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_saved_va  <= '0;
            r_shift     <= '0;
            r_out_valid <= 1'b0;
            r_out_kind  <= ptw_pkg::KIND_READ_REQ;
        end else begin
            r_busy      <= n_busy;
            r_saved_va  <= n_saved_va;
            r_shift     <= n_shift;
            r_out_valid <= n_out_valid;
            r_out_kind  <= n_out_kind;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out_addr <= n_out_addr;
    end

    a_idle_shift_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_busy |-> (r_shift == '0))
        else $error("level shift not cleared while idle");

    a_busy_shift_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> (r_shift >= ptw_pkg::SHIFT_W'(ptw_pkg::PAGE_SHIFT) &&
                    r_shift <= ptw_pkg::SHIFT_W'(ptw_pkg::TOP_SHIFT)))
        else $error("level shift out of range during walk");

    a_translate_busy_rejects: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (pop && r_busy && !i_item.is_resp) |=>
            (r_out_valid && r_out_kind == ptw_pkg::KIND_REJECT && r_out_addr == '0))
        else $error("translate during walk not rejected");

    a_resp_idle_rejects: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (pop && !r_busy && i_item.is_resp) |=>
            (r_out_valid && r_out_kind == ptw_pkg::KIND_REJECT && !r_busy))
        else $error("response while idle not rejected");

endmodule
`default_nettype wire
